// ===== rtl/oversampled_taxel_scan_compensation_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the taxel scan compensation block
// Shared property forms, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef OVERSAMPLED_TAXEL_SCAN_COMPENSATION_TOP_ASSERT_SVH
`define OVERSAMPLED_TAXEL_SCAN_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication
`define OTSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/otsc_pkg.sv =====
// ----------------------------------------------------------------------------
// otsc_pkg
// Types and constants shared by the taxel scan compensation block.
// ----------------------------------------------------------------------------
package otsc_pkg;

    // sensor array geometry and offset
    localparam int ROWS        = 24;
    localparam int COLS        = 28;
    localparam int ZERO_OFFSET = 16;
    localparam int DEPTH       = ROWS * COLS;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // field widths
    localparam int VAL_W      = 15;
    localparam int RC_W       = 5;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // array bounds as sized constants for compares on row and column
    localparam logic [6:0] ROWS_C = 7'(ROWS);
    localparam logic [6:0] COLS_C = 7'(COLS);
    localparam logic [VAL_W:0] ZOFF_C = (VAL_W + 1)'(ZERO_OFFSET);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIBRATE_MODE  = 3'd0,
        CFG_SPREAD_LIMIT    = 3'd1,
        CFG_ABS_THRESHOLD   = 3'd2,
        CFG_DELTA_THRESHOLD = 3'd3,
        CFG_WINDOW_ROW_LO   = 3'd4,
        CFG_WINDOW_ROW_HI   = 3'd5,
        CFG_WINDOW_COL_LO   = 3'd6,
        CFG_WINDOW_COL_HI   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                first_of_sweep;
        logic [RC_W-1:0]     row;
        logic [RC_W-1:0]     column;
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } t_in_item;

    typedef struct packed {
        logic [RC_W-1:0]  out_row;
        logic [RC_W-1:0]  out_column;
        logic [VAL_W-1:0] value;
        logic             abs_hit;
        logic             delta_hit;
        logic             detected;
    } t_out_item;

    // table write request
    typedef struct packed {
        logic             we;
        logic             we_comp;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] comp;
        logic [VAL_W-1:0] prev;
    } t_tbl_wr;

    // table read data
    typedef struct packed {
        logic [VAL_W-1:0] comp;
        logic [VAL_W-1:0] prev;
    } t_tbl_rd;

endpackage

// ===== rtl/otsc_tables.sv =====
// ----------------------------------------------------------------------------
// otsc_tables
// Compensation and previous-scan memories with registered reads and a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module otsc_tables
    import otsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  t_tbl_wr          i_wr,
    output t_tbl_rd          o_rd,
    output logic             o_clearing
);

    logic [VAL_W-1:0] r_comp_mem [DEPTH];
    logic [VAL_W-1:0] r_prev_mem [DEPTH];

    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_idx;
    logic             n_clearing;
    logic [IDX_W-1:0] n_clr_idx;

    logic             w_we_comp;
    logic             w_we_prev;
    logic [IDX_W-1:0] w_idx;
    logic [VAL_W-1:0] w_comp;
    logic [VAL_W-1:0] w_prev;

    logic [VAL_W-1:0] r_rd_comp;
    logic [VAL_W-1:0] r_rd_prev;

    // sweep one entry per cycle until the last address is zeroed
    always_comb begin
        n_clearing = r_clearing;
        n_clr_idx  = r_clr_idx;
        if (r_clearing) begin
            n_clr_idx = r_clr_idx + IDX_W'(1);
            if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_idx  <= n_clr_idx;
        end
    end

    // select the write port source: clearing pass or datapath
    always_comb begin
        if (r_clearing) begin
            w_we_comp = 1'b1;
            w_we_prev = 1'b1;
            w_idx     = r_clr_idx;
            w_comp    = '0;
            w_prev    = '0;
        end else begin
            w_we_comp = i_wr.we_comp;
            w_we_prev = i_wr.we;
            w_idx     = i_wr.idx;
            w_comp    = i_wr.comp;
            w_prev    = i_wr.prev;
        end
    end

    // compensation memory
    always_ff @(posedge i_clk) begin
        if (w_we_comp) begin
            r_comp_mem[w_idx] <= w_comp;
        end
        if (i_rd_en) begin
            r_rd_comp <= r_comp_mem[i_rd_idx];
        end
    end

    // previous-scan memory
    always_ff @(posedge i_clk) begin
        if (w_we_prev) begin
            r_prev_mem[w_idx] <= w_prev;
        end
        if (i_rd_en) begin
            r_rd_prev <= r_prev_mem[i_rd_idx];
        end
    end

    assign o_rd.comp  = r_rd_comp;
    assign o_rd.prev  = r_rd_prev;
    assign o_clearing = r_clearing;

endmodule

// ===== rtl/oversampled_taxel_scan_compensation_top.sv =====
// ----------------------------------------------------------------------------
// Oversampled taxel scan compensation
// Running min/max over an element's oversamples, midrange, compensation
// against a calibration table and hit detection against the previous scan.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock while o_in_stall is low and
// raises o_out_valid with the element result once the beat marked last_sample
// has passed the compute stage into the output register, held until taken.
// Each beat costs one read of each table at accept; an element's last beat
// inside the array writes back when it leaves the compute stage; a result
// written back is forwarded to the very next beat so back-to-back elements
// at the same address stay exact. After reset the tables are zeroed one entry
// per clock, all ROWS*COLS = 672 entries, while o_in_stall stays high;
// configuration writes are taken during that time. A result waiting under
// i_out_stall holds the compute stage only while it holds another result.
// ----------------------------------------------------------------------------
module oversampled_taxel_scan_compensation_top
    import otsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic             r_cal;
    logic [VAL_W-1:0] r_spread;
    logic [VAL_W-1:0] r_abs_th;
    logic [VAL_W-1:0] r_delta_th;
    logic [RC_W-1:0]  r_row_lo;
    logic [RC_W-1:0]  r_row_hi;
    logic [RC_W-1:0]  r_col_lo;
    logic [RC_W-1:0]  r_col_hi;

    // running group state
    logic             r_open;
    logic [VAL_W-1:0] r_min;
    logic [VAL_W-1:0] r_max;
    logic             n_open;
    logic [VAL_W-1:0] n_min;
    logic [VAL_W-1:0] n_max;
    logic             r_detect;
    logic             n_detect;

    // compute stage
    logic             r_a_valid;
    logic             n_a_valid;
    logic             r_a_first;
    logic             r_a_last;
    logic [RC_W-1:0]  r_a_row;
    logic [RC_W-1:0]  r_a_col;
    logic [VAL_W-1:0] r_a_min;
    logic [VAL_W-1:0] r_a_max;
    logic             r_a_inside;
    logic [IDX_W-1:0] r_a_idx;
    logic             r_byp_comp;
    logic             r_byp_prev;
    logic [VAL_W-1:0] r_byp_comp_val;
    logic [VAL_W-1:0] r_byp_prev_val;

    // output register
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;

    // interconnect and combinational terms
    logic             w_in_acc;
    logic             w_a_adv;
    logic             w_clearing;
    logic [VAL_W-1:0] w_s;
    logic             w_in_inside;
    logic [IDX_W-1:0] w_in_idx;
    logic             w_match;
    t_tbl_wr          w_wr;
    t_tbl_rd          w_rd;
    logic [VAL_W-1:0] w_comp;
    logic [VAL_W-1:0] w_prev;
    logic [VAL_W:0]   w_sum;
    logic [VAL_W-1:0] w_mid;
    logic [VAL_W-1:0] w_spread;
    logic [VAL_W-1:0] w_v0;
    logic [VAL_W:0]   w_comp_off;
    logic [VAL_W-1:0] w_val;
    logic             w_in_win;
    logic             w_ahit;
    logic             w_dhit;
    logic             w_flag;
    t_out_item        w_out;

    // ------------------------------------------------------------------
    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal      <= 1'b1;
            r_spread   <= VAL_W'(64);
            r_abs_th   <= VAL_W'(32767);
            r_delta_th <= VAL_W'(32767);
            r_row_lo   <= '0;
            r_row_hi   <= RC_W'(24);
            r_col_lo   <= '0;
            r_col_hi   <= RC_W'(28);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CALIBRATE_MODE:  r_cal      <= i_cfg_data[0];
                CFG_SPREAD_LIMIT:    r_spread   <= i_cfg_data[VAL_W-1:0];
                CFG_ABS_THRESHOLD:   r_abs_th   <= i_cfg_data[VAL_W-1:0];
                CFG_DELTA_THRESHOLD: r_delta_th <= i_cfg_data[VAL_W-1:0];
                CFG_WINDOW_ROW_LO:   r_row_lo   <= i_cfg_data[RC_W-1:0];
                CFG_WINDOW_ROW_HI:   r_row_hi   <= i_cfg_data[RC_W-1:0];
                CFG_WINDOW_COL_LO:   r_col_lo   <= i_cfg_data[RC_W-1:0];
                CFG_WINDOW_COL_HI:   r_col_hi   <= i_cfg_data[RC_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: the compute stage drains unless its result is blocked
    assign w_a_adv    = r_a_valid && (!r_a_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = w_clearing || (r_a_valid && !w_a_adv);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // clamp negative samples to zero
    assign w_s = i_in_data.sample[SAMPLE_W-1] ? '0 : i_in_data.sample[VAL_W-1:0];

    // update running min and max on each accepted beat
    always_comb begin
        n_open = r_open;
        n_min  = r_min;
        n_max  = r_max;
        if (w_in_acc) begin
            if (!r_open) begin
                n_min = w_s;
                n_max = w_s;
            end else begin
                n_min = (w_s < r_min) ? w_s : r_min;
                n_max = (w_s > r_max) ? w_s : r_max;
            end
            n_open = !i_in_data.last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_min  <= '0;
            r_max  <= '0;
        end else begin
            r_open <= n_open;
            r_min  <= n_min;
            r_max  <= n_max;
        end
    end

    // table address of the incoming element
    assign w_in_inside = ({2'b00, i_in_data.row} < ROWS_C)
                      && ({2'b00, i_in_data.column} < COLS_C);
    assign w_in_idx    = IDX_W'(IDX_W'(i_in_data.row) * IDX_W'(COLS))
                       + IDX_W'(i_in_data.column);

    // forward a write that lands on the same edge as this beat's read
    assign w_match = w_wr.we && (w_wr.idx == w_in_idx);

    // ------------------------------------------------------------------
    // compute stage registers
    assign n_a_valid = w_in_acc ? 1'b1 : (w_a_adv ? 1'b0 : r_a_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_byp_comp <= 1'b0;
            r_byp_prev <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            if (w_in_acc) begin
                r_byp_comp <= w_match && w_wr.we_comp;
                r_byp_prev <= w_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_first      <= i_in_data.first_of_sweep;
            r_a_last       <= i_in_data.last_sample;
            r_a_row        <= i_in_data.row;
            r_a_col        <= i_in_data.column;
            r_a_min        <= n_min;
            r_a_max        <= n_max;
            r_a_inside     <= w_in_inside;
            r_a_idx        <= w_in_idx;
            r_byp_comp_val <= w_wr.comp;
            r_byp_prev_val <= w_wr.prev;
        end
    end

    // table entries for this element, zero outside the array
    always_comb begin
        w_comp = '0;
        w_prev = '0;
        if (r_a_inside) begin
            w_comp = r_byp_comp ? r_byp_comp_val : w_rd.comp;
            w_prev = r_byp_prev ? r_byp_prev_val : w_rd.prev;
        end
    end

    // midrange, spread check and compensation
    assign w_sum      = {1'b0, r_a_min} + {1'b0, r_a_max};
    assign w_mid      = w_sum[VAL_W:1];
    assign w_spread   = r_a_max - r_a_min;
    assign w_v0       = (w_spread > r_spread) ? '0 : w_mid;
    assign w_comp_off = {1'b0, w_comp} + ZOFF_C;
    assign w_val      = (w_comp_off > {1'b0, w_v0}) ? '0 : (w_v0 - w_comp);

    // window and hit tests
    assign w_in_win = r_a_inside
                   && (r_a_row >= r_row_lo) && (r_a_row < r_row_hi)
                   && (r_a_col >= r_col_lo) && (r_a_col < r_col_hi);
    assign w_ahit   = !r_cal && w_in_win && (w_val >= r_abs_th);
    assign w_dhit   = !r_cal && w_in_win && (w_val > w_prev)
                   && ((w_val - w_prev) >= r_delta_th);

    // sticky detect flag, cleared at sweep start
    assign w_flag   = r_a_first ? 1'b0 : r_detect;
    assign n_detect = w_a_adv ? (w_flag || (r_a_last && (w_ahit || w_dhit))) : r_detect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect <= 1'b0;
        end else begin
            r_detect <= n_detect;
        end
    end

    // write back when the last beat of an element leaves the stage
    always_comb begin
        w_wr.we      = w_a_adv && r_a_last && r_a_inside;
        w_wr.we_comp = w_a_adv && r_a_last && r_a_inside && r_cal;
        w_wr.idx     = r_a_idx;
        w_wr.comp    = w_mid;
        w_wr.prev    = r_cal ? '0 : w_val;
    end

    otsc_tables u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_acc),
        .i_rd_idx   (w_in_idx),
        .i_wr       (w_wr),
        .o_rd       (w_rd),
        .o_clearing (w_clearing)
    );

    // ------------------------------------------------------------------
    // result beat
    always_comb begin
        w_out.out_row    = r_a_row;
        w_out.out_column = r_a_col;
        w_out.value      = r_cal ? w_mid : w_val;
        w_out.abs_hit    = w_ahit;
        w_out.delta_hit  = w_dhit;
        w_out.detected   = w_flag || w_ahit || w_dhit;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_a_adv && r_a_last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv && r_a_last) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/otsc_checker.sv =====
// ----------------------------------------------------------------------------
// otsc_checker
// Port-level checks on the taxel scan compensation block, bound to the top.
// ----------------------------------------------------------------------------
`include "oversampled_taxel_scan_compensation_top_assert.svh"

module otsc_checker
    import otsc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // hold a stalled result beat
    `OTSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled result beat changed")

    // any hit in a result sets detected
    `OTSC_ASSERT_NOW(a_hit_detect, i_clk, i_rst_n,
        o_out_valid && (o_out_data.abs_hit || o_out_data.delta_hit),
        o_out_data.detected, "hit without detected flag")

    // a delta hit needs a rise, so the value cannot be zero
    `OTSC_ASSERT_NOW(a_delta_nonzero, i_clk, i_rst_n,
        o_out_valid && o_out_data.delta_hit,
        o_out_data.value != '0, "delta hit on zero value")

    // table clearing holds off input right after reset
    `OTSC_ASSERT_NOW(a_clear_stall, i_clk, i_rst_n,
        !$past(i_rst_n), o_in_stall, "input taken before table clear")

endmodule

bind oversampled_taxel_scan_compensation_top otsc_checker u_otsc_checker (.*);
